// ===== rtl/tdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdt_pkg: shared types and codes for the task dispatch tracker.
// Holds the input and result structs, command and result codes.
// ----------------------------------------------------------------------------
package tdt_pkg;

  localparam int TASK_SLOTS_DEF   = 64;
  localparam int CLIENT_SLOTS_DEF = 8;
  localparam int MAX_OUT          = 8;

  localparam logic [2:0] CMD_START      = 3'd0;
  localparam logic [2:0] CMD_CONNECT    = 3'd1;
  localparam logic [2:0] CMD_DISCONNECT = 3'd2;
  localparam logic [2:0] CMD_RESPONSE   = 3'd3;
  localparam logic [2:0] CMD_DISPATCH   = 3'd4;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_ASSIGN  = 2'd1;
  localparam logic [1:0] KIND_NOTHING = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOTAL     = 2'd1;
  localparam logic [1:0] ERR_TASK      = 2'd2;
  localparam logic [1:0] ERR_CLIENT    = 2'd3;

  localparam logic [1:0] RS_COMPLETE = 2'd0;
  localparam logic [1:0] RS_UNKNOWN  = 2'd2;

  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_PROGRESS   = 2'd1;
  localparam logic [1:0] ST_COMPLETE   = 2'd2;

  localparam logic [6:0] REG_TASK_TOTAL = 7'd0;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] client_id;
    logic [5:0] task_id;
    logic [1:0] report_status;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] error_code;
    logic [3:0] assigned_client;
    logic [5:0] assigned_task;
    logic       all_done;
    logic       last;
  } out_item_t;

  // Classified command as handed from the front to the back.
  typedef struct packed {
    logic [2:0] command;
    logic       err;
    logic [1:0] error_code;
    logic [3:0] client_id;
    logic [5:0] task_id;
    logic [1:0] report_status;
  } job_t;

endpackage

// ===== rtl/tdt_front.sv =====
// ----------------------------------------------------------------------------
// tdt_front: input stage with a two-entry queue.
// Checks client ids and task totals and queues classified jobs.
// ----------------------------------------------------------------------------
module tdt_front #(
  parameter int TASK_SLOTS   = tdt_pkg::TASK_SLOTS_DEF,
  parameter int CLIENT_SLOTS = tdt_pkg::CLIENT_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tdt_pkg::in_item_t in_data,
  input  logic [6:0]        task_total,
  output logic              job_valid,
  input  logic              job_take,
  output tdt_pkg::job_t     job
);

  tdt_pkg::job_t q [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  tdt_pkg::job_t cls;
  logic          acc;

  always_comb begin
    cls.command       = in_data.command;
    cls.client_id     = in_data.client_id;
    cls.task_id       = in_data.task_id;
    cls.report_status = in_data.report_status;
    cls.err           = 1'b0;
    cls.error_code    = tdt_pkg::ERR_NONE;
    if (in_data.command == tdt_pkg::CMD_START) begin
      if (32'(task_total) > 32'(TASK_SLOTS)) begin
        cls.err        = 1'b1;
        cls.error_code = tdt_pkg::ERR_TOTAL;
      end
    end else if (in_data.command inside {tdt_pkg::CMD_CONNECT, tdt_pkg::CMD_DISCONNECT,
                                         tdt_pkg::CMD_RESPONSE}) begin
      if (in_data.client_id == 4'd0 || 32'(in_data.client_id) > 32'(CLIENT_SLOTS)) begin
        cls.err        = 1'b1;
        cls.error_code = tdt_pkg::ERR_CLIENT;
      end
    end
  end

  assign in_stall  = (count == 2'd2);
  assign acc       = in_valid && !in_stall;
  assign job_valid = (count != 2'd0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (acc) q[wr_ptr] <= cls;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (acc) wr_ptr <= ~wr_ptr;
      if (job_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, acc} - {1'b0, job_take};
    end
  end

endmodule

// ===== rtl/tdt_back.sv =====
// ----------------------------------------------------------------------------
// tdt_back: execution sequencer.
// Walks tasks on start, clients on dispatch, and checks completion.
// ----------------------------------------------------------------------------
module tdt_back #(
  parameter int TASK_SLOTS   = tdt_pkg::TASK_SLOTS_DEF,
  parameter int CLIENT_SLOTS = tdt_pkg::CLIENT_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_take,
  input  tdt_pkg::job_t      job,
  input  logic [6:0]         task_total,
  output logic               out_valid,
  input  logic               out_stall,
  output tdt_pkg::out_item_t out_data
);

  localparam int TW = $clog2(TASK_SLOTS);
  localparam int CW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int FW = $clog2(TASK_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [2:0]    state;
  tdt_pkg::job_t cur;

  // Only completion matters for the results, so each task keeps one flag.
  logic [TASK_SLOTS-1:0] done_bits;
  logic [TASK_SLOTS-1:0] live_mask;
  logic [TW-1:0] ring [TASK_SLOTS];
  logic [TW-1:0] head, tail;
  logic [FW-1:0] fill;
  logic [CLIENT_SLOTS-1:0] conn, busy;

  // Slots handed a task by the current dispatch, and the task each got.
  logic [CLIENT_SLOTS-1:0] amask;
  logic [CLIENT_SLOTS-1:0] amask_rest;
  logic [TW-1:0] stask [CLIENT_SLOTS];

  logic [FW-1:0] walk;     // start fill index
  logic [CW-1:0] slot;     // dispatch walk index
  logic [3:0]    given;
  logic [TW-1:0] rd_data;
  logic          rd_pend;

  logic               out_v;
  tdt_pkg::out_item_t out_r;
  logic               out_free;
  logic               emit;

  logic [FW-1:0] live;
  logic          all_done;
  logic [CW-1:0] cs;
  logic [TW-1:0] ct;
  logic [CW-1:0] ccs;

  assign live = (32'(task_total) > 32'(TASK_SLOTS)) ? FW'(TASK_SLOTS) : FW'(task_total);

  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) live_mask[i] = (i < int'(live));
  end

  assign all_done = &(done_bits | ~live_mask);

  assign out_valid = out_v;
  assign out_data  = out_r;
  assign out_free  = !out_v || !out_stall;

  assign amask_rest = amask & ~(CLIENT_SLOTS'(1) << slot);
  assign emit = out_free && ((state == S_EMIT) ||
                ((state == S_DRAIN) && (given == 4'd0 || amask[slot])));

  assign job_take = (state == S_IDLE) && job_valid;

  assign cs  = CW'(job.client_id - 4'd1);
  assign ct  = TW'(cur.task_id);
  assign ccs = CW'(cur.client_id - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      done_bits <= '0;
      conn      <= '0;
      busy      <= '0;
      out_v     <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      out_v <= emit || (out_v && out_stall);
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            if (job.err) begin
              state <= S_EMIT;
            end else if (job.command == tdt_pkg::CMD_START) begin
              done_bits <= '0;
              head <= '0;
              tail <= '0;
              fill <= '0;
              walk <= '0;
              state <= S_START;
            end else if (job.command == tdt_pkg::CMD_CONNECT) begin
              conn[cs] <= 1'b1;
              busy[cs] <= 1'b0;
              state <= S_WAIT;
            end else if (job.command == tdt_pkg::CMD_DISCONNECT) begin
              conn[cs] <= 1'b0;
              busy[cs] <= 1'b0;
              state <= S_WAIT;
            end else if (job.command == tdt_pkg::CMD_DISPATCH) begin
              slot    <= '0;
              given   <= '0;
              amask   <= '0;
              rd_pend <= 1'b0;
              state   <= S_DISP;
            end else begin
              state <= S_WAIT;
            end
          end
        end
        S_START: begin
          if (32'(walk) < 32'(task_total)) begin
            ring[TW'(walk)] <= TW'(walk);
            walk <= walk + FW'(1);
          end else begin
            tail  <= TW'(walk);
            fill  <= walk;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          // Response handling is done here so checks see the cap.
          if (cur.command == tdt_pkg::CMD_RESPONSE) begin
            if (32'(cur.task_id) >= 32'(live)) begin
              cur.err        <= 1'b1;
              cur.error_code <= tdt_pkg::ERR_TASK;
            end else if (cur.report_status == tdt_pkg::RS_COMPLETE) begin
              done_bits[ct] <= 1'b1;
              busy[ccs] <= 1'b0;
            end else if (cur.report_status == tdt_pkg::RS_UNKNOWN) begin
              done_bits[ct] <= 1'b0;
              busy[ccs] <= 1'b0;
              if (32'(fill) < 32'(TASK_SLOTS)) begin
                ring[tail] <= ct;
                tail <= (32'(tail) + 1 >= TASK_SLOTS) ? '0 : tail + TW'(1);
                fill <= fill + FW'(1);
              end
            end
          end
          state <= S_EMIT;
        end
        S_DISP: begin
          // A popped task arrives in the cycle after its read; then the next slot.
          if (rd_pend) begin
            done_bits[rd_data] <= 1'b0;
            stask[slot] <= rd_data;
            amask[slot] <= 1'b1;
            rd_pend <= 1'b0;
            given   <= given + 4'd1;
            if (32'(slot) == CLIENT_SLOTS - 1 || given + 4'd1 == 4'(tdt_pkg::MAX_OUT)) begin
              slot  <= '0;
              state <= S_DRAIN;
            end else begin
              slot <= slot + CW'(1);
            end
          end else if (conn[slot] && !busy[slot] && fill != '0) begin
            rd_data <= ring[head];
            head    <= (32'(head) + 1 >= TASK_SLOTS) ? '0 : head + TW'(1);
            fill    <= fill - FW'(1);
            busy[slot] <= 1'b1;
            rd_pend <= 1'b1;
          end else if ((conn[slot] && !busy[slot]) || 32'(slot) == CLIENT_SLOTS - 1) begin
            slot  <= '0;
            state <= S_DRAIN;
          end else begin
            slot <= slot + CW'(1);
          end
        end
        S_DRAIN: begin
          // Results leave after the walk so all of them carry the final all_done.
          if (given == 4'd0) begin
            if (out_free) begin
              out_r.kind            <= tdt_pkg::KIND_NOTHING;
              out_r.error_code      <= tdt_pkg::ERR_NONE;
              out_r.assigned_client <= 4'd0;
              out_r.assigned_task   <= 6'd0;
              out_r.all_done        <= all_done;
              out_r.last            <= 1'b1;
              state <= S_IDLE;
            end
          end else if (amask[slot]) begin
            if (out_free) begin
              out_r.kind            <= tdt_pkg::KIND_ASSIGN;
              out_r.error_code      <= tdt_pkg::ERR_NONE;
              out_r.assigned_client <= 4'(slot) + 4'd1;
              out_r.assigned_task   <= 6'(stask[slot]);
              out_r.all_done        <= all_done;
              out_r.last            <= (amask_rest == '0);
              amask <= amask_rest;
              if (amask_rest == '0)
                state <= S_IDLE;
              else
                slot <= slot + CW'(1);
            end
          end else begin
            slot <= slot + CW'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_r.kind            <= cur.err ? tdt_pkg::KIND_ERROR : tdt_pkg::KIND_ACK;
            out_r.error_code      <= cur.err ? cur.error_code : tdt_pkg::ERR_NONE;
            out_r.assigned_client <= 4'd0;
            out_r.assigned_task   <= 6'd0;
            out_r.all_done        <= all_done;
            out_r.last            <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/task_dispatch_tracker_top.sv =====
// ----------------------------------------------------------------------------
// task_dispatch_tracker_top: work distributor with client slot tracking.
// Each command yields registered results; a command rejected by the front skips
// the wait state, and start loads the ring with one entry per task first.
// Dispatch walks the slots, taking a task from the ring for each connected idle
// client while tasks remain, then sends its results in slot order.
// One command runs at a time; a two-entry queue buffers arrivals.
// Synchronous reset clears all task states, the ring pointers and slots.
// ----------------------------------------------------------------------------
module task_dispatch_tracker_top #(
  parameter int TASK_SLOTS   = tdt_pkg::TASK_SLOTS_DEF,
  parameter int CLIENT_SLOTS = tdt_pkg::CLIENT_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tdt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tdt_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [6:0]         task_total;
  logic               job_valid, job_take;
  tdt_pkg::job_t      job;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign prdata = {25'd0, task_total};

  always_ff @(posedge clk) begin
    if (rst) begin
      task_total <= 7'd0;
    end else if (wr && paddr == 1'b0) begin
      task_total <= pwdata[6:0];
    end
  end

  tdt_front #(.TASK_SLOTS(TASK_SLOTS), .CLIENT_SLOTS(CLIENT_SLOTS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .task_total,
    .job_valid, .job_take, .job
  );

  tdt_back #(.TASK_SLOTS(TASK_SLOTS), .CLIENT_SLOTS(CLIENT_SLOTS)) u_back (
    .clk, .rst, .job_valid, .job_take, .job, .task_total,
    .out_valid, .out_stall, .out_data
  );

endmodule

// ===== sim/tb_task_dispatch_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Task dispatch tracker testbench
// Drives command transfers with random bursts and gaps while the result side
// stalls on its own pattern. A built-in tracker model predicts every result
// transfer, and each received result is checked field by field. task_total
// is rewritten between phases, including zero, the ring size and too-large
// values.
// ----------------------------------------------------------------------------
module tb_task_dispatch_tracker_top;
  import tdt_pkg::*;

  localparam int TASKS        = 64;
  localparam int CLIENTS      = 8;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [1:0] RS_PROGRESS     = 2'd1;
  localparam logic [1:0] RS_SPARE        = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  task_dispatch_tracker_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Tracker state mirrored by the testbench.
  int unsigned total_cfg;
  logic [1:0] task_st[TASKS];
  logic [5:0] pending[TASKS];
  int unsigned head, tail, fill;
  bit connected[CLIENTS];
  bit busy[CLIENTS];

  in_item_t command_queue[$];
  out_item_t expected_results[$];
  int unsigned errors = 0;
  int unsigned commands_sent = 0;
  int unsigned results_seen = 0;
  int unsigned assignments_seen = 0;
  int unsigned cycles = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s at cycle %0d: got %0d, expected %0d", what, cycles, got, want);
    errors++;
  endtask

  function automatic int unsigned live_total();
    return (total_cfg > TASKS) ? TASKS : total_cfg;
  endfunction

  function automatic void requeue(logic [5:0] t);
    if (fill < TASKS) begin
      pending[tail] = t;
      tail = (tail + 1) % TASKS;
      fill++;
    end
  endfunction

  function automatic void predict_results(in_item_t it);
    out_item_t res[$];
    out_item_t r;
    int unsigned s;
    bit done;
    r = '0;
    r.kind = KIND_ACK;
    if (it.command == CMD_START) begin
      if (total_cfg > TASKS) begin
        r.kind = KIND_ERROR;
        r.error_code = ERR_TOTAL;
      end else begin
        foreach (task_st[i]) task_st[i] = ST_INCOMPLETE;
        head = 0;
        tail = 0;
        fill = 0;
        for (int i = 0; i < total_cfg; i++) requeue(i[5:0]);
      end
      res.push_back(r);
    end else if (it.command inside {CMD_CONNECT, CMD_DISCONNECT, CMD_RESPONSE}) begin
      if (it.client_id == 0 || it.client_id > CLIENTS) begin
        r.kind = KIND_ERROR;
        r.error_code = ERR_CLIENT;
      end else begin
        s = it.client_id - 1;
        if (it.command == CMD_CONNECT) begin
          connected[s] = 1'b1;
          busy[s] = 1'b0;
        end else if (it.command == CMD_DISCONNECT) begin
          connected[s] = 1'b0;
          busy[s] = 1'b0;
        end else if (it.task_id >= live_total()) begin
          r.kind = KIND_ERROR;
          r.error_code = ERR_TASK;
        end else if (it.report_status == RS_COMPLETE) begin
          task_st[it.task_id] = ST_COMPLETE;
          busy[s] = 1'b0;
        end else if (it.report_status == RS_UNKNOWN) begin
          task_st[it.task_id] = ST_INCOMPLETE;
          requeue(it.task_id);
          busy[s] = 1'b0;
        end
      end
      res.push_back(r);
    end else if (it.command == CMD_DISPATCH) begin
      for (int i = 0; i < CLIENTS; i++) begin
        if (connected[i] && !busy[i]) begin
          if (fill == 0) break;
          r = '0;
          r.kind = KIND_ASSIGN;
          r.assigned_client = 4'(i + 1);
          r.assigned_task = pending[head];
          head = (head + 1) % TASKS;
          fill--;
          task_st[r.assigned_task] = ST_PROGRESS;
          busy[i] = 1'b1;
          res.push_back(r);
        end
      end
      if (res.size() == 0) begin
        r = '0;
        r.kind = KIND_NOTHING;
        res.push_back(r);
      end
    end else begin
      res.push_back(r);
    end
    done = 1'b1;
    for (int i = 0; i < live_total(); i++) if (task_st[i] != ST_COMPLETE) done = 1'b0;
    foreach (res[k]) begin
      res[k].all_done = done;
      res[k].last = (k == res.size() - 1);
      expected_results.push_back(res[k]);
    end
  endfunction

  function automatic in_item_t make_cmd(logic [2:0] c, int cl, int t, logic [1:0] st);
    in_item_t it;
    it.command = c;
    it.client_id = 4'(cl);
    it.task_id = 6'(t);
    it.report_status = st;
    return it;
  endfunction

  // Mostly meaningful traffic; a slice of fully random bits as noise.
  function automatic in_item_t random_cmd(int unsigned tot);
    int unsigned pick;
    int unsigned span;
    in_item_t it;
    pick = $urandom_range(99);
    span = (tot == 0) ? 1 : ((tot > TASKS) ? TASKS : tot);
    it = make_cmd(CMD_RESPONSE, $urandom_range(1, CLIENTS), $urandom_range(0, span - 1),
                  ($urandom_range(3) == 0) ? 2'($urandom_range(1, 3)) : RS_COMPLETE);
    if (pick < 4) it.command = CMD_START;
    else if (pick < 18) it.command = CMD_CONNECT;
    else if (pick < 25) it.command = CMD_DISCONNECT;
    else if (pick < 65) it.command = CMD_RESPONSE;
    else if (pick < 90) it.command = CMD_DISPATCH;
    else it = in_item_t'(15'($urandom));
    if (pick >= 4 && pick < 65 && $urandom_range(15) == 0) it.client_id = 4'($urandom);
    return it;
  endfunction

  // Driver: bursts of transfers separated by random gaps.
  bit in_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_results(in_data);
      commands_sent++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (in_taken || !in_valid) begin
      in_taken = 1'b0;
      if (rst || command_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_data <= command_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // Receiver stall pattern switches at random among four modes.
  int unsigned stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 300 == 0) stall_mode = $urandom_range(3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(9) < 3);
      2: out_stall <= ($urandom_range(9) < 7);
      default: out_stall <= ((cycles / 5) % 3 == 0);
    endcase
  end

  // Monitor.
  always @(posedge clk) begin
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transfer", int'(out_data), 0);
      end else begin
        out_item_t want;
        want = expected_results.pop_front();
        if (out_data.kind == KIND_ASSIGN) assignments_seen++;
        if (out_data.kind != want.kind) report_mismatch("kind", out_data.kind, want.kind);
        if (out_data.error_code != want.error_code)
          report_mismatch("error_code", out_data.error_code, want.error_code);
        if (out_data.assigned_client != want.assigned_client)
          report_mismatch("assigned_client", out_data.assigned_client, want.assigned_client);
        if (out_data.assigned_task != want.assigned_task)
          report_mismatch("assigned_task", out_data.assigned_task, want.assigned_task);
        if (out_data.all_done != want.all_done)
          report_mismatch("all_done", out_data.all_done, want.all_done);
        if (out_data.last != want.last) report_mismatch("last", out_data.last, want.last);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic wait_idle();
    while (command_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_total(int unsigned value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_TASK_TOTAL[0:0];
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    total_cfg = value & 7'h7f;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  int unsigned totals[8] = '{0, 64, 100, 127, 13, 1, 64, 6};

  initial begin
    total_cfg = 0;
    head = 0;
    tail = 0;
    fill = 0;
    foreach (task_st[i]) task_st[i] = ST_INCOMPLETE;
    foreach (connected[i]) begin
      connected[i] = 1'b0;
      busy[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_total(4);
    command_queue.push_back(make_cmd(CMD_DISPATCH, 0, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_CONNECT, 0, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_CONNECT, 9, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_RESPONSE, 15, 63, RS_SPARE));
    command_queue.push_back(make_cmd(CMD_CONNECT, 1, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_CONNECT, 2, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_CONNECT, 8, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_START, 0, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_DISPATCH, 0, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_RESPONSE, 1, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_RESPONSE, 2, 63, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_RESPONSE, 2, 1, RS_PROGRESS));
    command_queue.push_back(make_cmd(CMD_RESPONSE, 8, 2, RS_SPARE));
    command_queue.push_back(make_cmd(CMD_RESPONSE, 2, 1, RS_UNKNOWN));
    command_queue.push_back(make_cmd(CMD_RESPONSE, 5, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_DISCONNECT, 8, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_SPARE_FIRST, 3, 5, RS_UNKNOWN));
    command_queue.push_back(make_cmd(CMD_SPARE_LAST, 15, 63, RS_SPARE));
    for (int c = 3; c <= 8; c++) command_queue.push_back(make_cmd(CMD_CONNECT, c, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_DISPATCH, 0, 0, RS_COMPLETE));
    command_queue.push_back(make_cmd(CMD_DISPATCH, 0, 0, RS_COMPLETE));

    foreach (totals[p]) begin
      wait_idle();
      write_total(totals[p]);
      command_queue.push_back(make_cmd(CMD_START, 0, 0, RS_COMPLETE));
      for (int c = 1; c <= CLIENTS; c++)
        if ($urandom_range(1)) command_queue.push_back(make_cmd(CMD_CONNECT, c, 0, RS_COMPLETE));
      repeat (30) command_queue.push_back(random_cmd(totals[p]));
    end

    wait_idle();
    $display("sent %0d commands over %0d task_total settings", commands_sent, 9);
    $display("checked %0d results, %0d of them task assignments", results_seen,
             assignments_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tdt_pkg.sv
rtl/tdt_front.sv
rtl/tdt_back.sv
rtl/task_dispatch_tracker_top.sv
sim/tb_task_dispatch_tracker_top.sv
